// ===== rtl/core/smlp_pkg.sv =====
// Shared types, codes and constants of the SIP message line parser.
// No dependencies; imported by sip_message_line_parser.

package smlp_pkg;

    localparam int DEFAULT_OFFSET_BITS = 16;
    localparam int OUT_FIELD_BITS      = 16;
    localparam int STATUS_BITS         = 10;
    localparam int MIN_MESSAGE         = 12;
    localparam int QUEUE_DEPTH         = 4;
    localparam int PREFIX_LEN          = 8;
    localparam int CODE_DONE           = 11;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_HEADERS = 2'd1,
        PH_BODY    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        KIND_REQUEST      = 3'd0,
        KIND_STATUS       = 3'd1,
        KIND_UNRECOGNIZED = 3'd2,
        KIND_HEADER       = 3'd3,
        KIND_END_OK       = 3'd4,
        KIND_TOO_SHORT    = 3'd5,
        KIND_TOO_LONG     = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic [OUT_FIELD_BITS-1:0] first_offset;
        logic [OUT_FIELD_BITS-1:0] first_length;
        logic [OUT_FIELD_BITS-1:0] second_offset;
        logic [OUT_FIELD_BITS-1:0] second_length;
        logic                      part_present;
        logic [STATUS_BITS-1:0]    status_value;
        logic                      run_last;
    } rec_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h53;
            3'd1: c = 8'h49;
            3'd2: c = 8'h50;
            3'd3: c = 8'h2F;
            3'd4: c = 8'h32;
            3'd5: c = 8'h2E;
            3'd6: c = 8'h30;
            3'd7: c = CH_SPACE;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/sip_message_line_parser.sv =====
// SIP message line parser: byte stream in, start line, header and end items out.
// Depends on smlp_pkg for record layout, phase and kind codes.

// Takes one message byte per cycle on the slave stream while s_tready is high (tlast marks the
// final byte of the message) and emits one item per start line and per header line with a
// colon, plus an end item after the final byte, on the master stream. The byte is parsed in
// the cycle it is accepted; its items enter a four-entry output queue, which presents them
// from the next cycle on. Sustained rate is one byte per cycle while the queue has room; the
// final byte of a message can queue two items, which drain one per cycle while m_tready is
// high. s_tready drops only while the queue has fewer than two free entries. m_tuser carries
// the record kind; m_tlast flags the last item caused by one byte. On a too short or too long
// end item the consumer discards the whole run of items of that message.

module sip_message_line_parser
    import smlp_pkg::*;
#(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [15:0] first_offset, [31:16] first_length,
                                   // [47:32] second_offset, [63:48] second_length,
                                   // [64] part_present, [74:65] status_value, zero fill
    output logic [2:0]  m_tuser,   // [2:0] record_kind
    output logic        m_tlast    // run_last
);

    localparam int OB      = OFFSET_BITS;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [OB:0]   bpos;
        phase_t        phase;
        logic          pending_cr;
        logic [OB-1:0] line_begin;
        logic [3:0]    prefix_progress;
        logic          prefix_failed;
        logic [9:0]    code_accum;
        logic          code_ok;
        logic [OB-1:0] reason_begin;
        logic [1:0]    space_count;
        logic [OB-1:0] space_one_pos;
        logic [OB-1:0] space_two_pos;
        logic          colon_seen;
        logic [OB-1:0] colon_pos;
        logic [OB-1:0] value_begin;
        logic          value_started;
        logic [OB-1:0] value_end;
        logic [OB-1:0] body_begin;
    } pstate_t;

    function automatic logic [OUT_FIELD_BITS-1:0] to_out(input logic [OB-1:0] v);
        logic [OB+OUT_FIELD_BITS-1:0] x;
        x = {{OUT_FIELD_BITS{1'b0}}, v};
        return x[OUT_FIELD_BITS-1:0];
    endfunction

    function automatic rec_t mk_rec(input kind_t k, input logic [OB-1:0] fo,
                                    input logic [OB-1:0] fl, input logic [OB-1:0] so,
                                    input logic [OB-1:0] sl, input logic pres,
                                    input logic [STATUS_BITS-1:0] st);
        rec_t r;
        r.kind          = k;
        r.first_offset  = to_out(fo);
        r.first_length  = to_out(fl);
        r.second_offset = to_out(so);
        r.second_length = to_out(sl);
        r.part_present  = pres;
        r.status_value  = st;
        r.run_last      = 1'b0;
        return r;
    endfunction

    function automatic pstate_t reset_state();
        pstate_t s;
        s       = '0;
        s.phase = PH_START;
        return s;
    endfunction

    function automatic pstate_t clear_line(input pstate_t s);
        pstate_t r;
        r                 = s;
        r.prefix_progress = '0;
        r.prefix_failed   = 1'b0;
        r.code_accum      = '0;
        r.code_ok         = 1'b0;
        r.reason_begin    = '0;
        r.space_count     = '0;
        r.space_one_pos   = '0;
        r.space_two_pos   = '0;
        r.colon_seen      = 1'b0;
        r.colon_pos       = '0;
        r.value_begin     = '0;
        r.value_started   = 1'b0;
        r.value_end       = '0;
        return r;
    endfunction

    function automatic pstate_t start_content(input pstate_t s, input logic [7:0] b,
                                              input logic [OB-1:0] p);
        pstate_t       r;
        logic [OB-1:0] p1;
        logic [13:0]   acc;
        r   = s;
        p1  = p + OB'(1);
        acc = 14'(s.code_accum) * 14'd10 + 14'(b - CH_ZERO);
        if (!s.prefix_failed && s.prefix_progress < 4'(CODE_DONE)) begin
            if (s.prefix_progress < 4'(PREFIX_LEN)) begin
                if (b == prefix_char(s.prefix_progress[2:0])) begin
                    r.prefix_progress = s.prefix_progress + 4'd1;
                end else begin
                    r.prefix_failed = 1'b1;
                end
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
                r.code_accum      = acc[9:0];
                r.prefix_progress = s.prefix_progress + 4'd1;
                if (s.prefix_progress == 4'(CODE_DONE - 1)) begin
                    r.code_ok      = 1'b1;
                    r.reason_begin = p1;
                end
            end else begin
                r.prefix_failed = 1'b1;
            end
        end else if (s.code_ok && b == CH_SPACE && s.reason_begin == p) begin
            r.reason_begin = p1;
        end
        if (b == CH_SPACE) begin
            if (s.space_count == 2'd0) begin
                r.space_one_pos = p;
                r.space_count   = 2'd1;
            end else if (s.space_count == 2'd1) begin
                r.space_two_pos = p;
                r.space_count   = 2'd2;
            end
        end
        return r;
    endfunction

    function automatic pstate_t header_content(input pstate_t s, input logic [7:0] b,
                                               input logic [OB-1:0] p);
        pstate_t r;
        r = s;
        if (!s.colon_seen) begin
            if (b == CH_COLON) begin
                r.colon_seen = 1'b1;
                r.colon_pos  = p;
            end
        end else if (b != CH_SPACE && b != CH_TAB) begin
            if (!s.value_started) begin
                r.value_started = 1'b1;
                r.value_begin   = p;
            end
            r.value_end = p + OB'(1);
        end
        return r;
    endfunction

    function automatic rec_t start_rec(input pstate_t s, input logic [OB-1:0] le);
        rec_t r;
        if (s.code_ok) begin
            r = mk_rec(KIND_STATUS, s.reason_begin, le - s.reason_begin, '0, '0, 1'b0,
                       s.code_accum);
        end else if (s.prefix_progress >= 4'(PREFIX_LEN) || s.space_count == 2'd0) begin
            r = mk_rec(KIND_UNRECOGNIZED, '0, '0, '0, '0, 1'b0, '0);
        end else if (s.space_count >= 2'd2) begin
            r = mk_rec(KIND_REQUEST, s.line_begin, s.space_one_pos - s.line_begin,
                       s.space_one_pos + OB'(1),
                       s.space_two_pos - s.space_one_pos - OB'(1), 1'b1, '0);
        end else begin
            r = mk_rec(KIND_REQUEST, s.line_begin, s.space_one_pos - s.line_begin,
                       '0, '0, 1'b0, '0);
        end
        return r;
    endfunction

    function automatic rec_t header_rec(input pstate_t s, input logic [OB-1:0] le);
        rec_t r;
        if (s.value_started) begin
            r = mk_rec(KIND_HEADER, s.line_begin, s.colon_pos - s.line_begin,
                       s.value_begin, s.value_end - s.value_begin, 1'b0, '0);
        end else begin
            r = mk_rec(KIND_HEADER, s.line_begin, s.colon_pos - s.line_begin,
                       le, '0, 1'b0, '0);
        end
        return r;
    endfunction

    pstate_t          st_reg;
    pstate_t          st_mid;
    pstate_t          st_next;
    rec_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic          in_acc;
    logic          out_acc;
    logic [OB-1:0] pos;
    logic [OB-1:0] pos_next;
    logic [OB-1:0] end_pos;
    logic [OB:0]   total;
    logic          is_eol;
    logic          eol_path;
    logic          line_v;
    logic          end_v;
    rec_t          line_rec;
    rec_t          end_rec;
    rec_t          head;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign s_tready = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);

    assign pos      = st_reg.bpos[OB-1:0];
    assign pos_next = pos + OB'(1);
    assign is_eol   = (s_tdata == CH_CR) || (s_tdata == CH_LF);

    always_comb begin
        st_mid   = st_reg;
        eol_path = 1'b0;
        if (st_reg.pending_cr && s_tdata == CH_LF) begin
            st_mid.pending_cr = 1'b0;
            st_mid.line_begin = pos_next;
            if (st_reg.phase != PH_START && st_reg.phase != PH_HEADERS) begin
                st_mid.body_begin = pos_next;
            end
        end else begin
            st_mid.pending_cr = 1'b0;
            unique case (st_reg.phase)
                PH_START: begin
                    if (is_eol) begin
                        eol_path          = 1'b1;
                        st_mid            = clear_line(st_mid);
                        st_mid.phase      = PH_HEADERS;
                        st_mid.line_begin = pos_next;
                        st_mid.pending_cr = (s_tdata == CH_CR);
                    end else begin
                        st_mid = start_content(st_mid, s_tdata, pos);
                    end
                end
                PH_HEADERS: begin
                    if (is_eol) begin
                        eol_path = 1'b1;
                        st_mid   = clear_line(st_mid);
                        if (pos == st_reg.line_begin) begin
                            st_mid.phase      = PH_BODY;
                            st_mid.body_begin = pos_next;
                        end else begin
                            st_mid.line_begin = pos_next;
                        end
                        st_mid.pending_cr = (s_tdata == CH_CR);
                    end else begin
                        st_mid = header_content(st_mid, s_tdata, pos);
                    end
                end
                default: begin
                end
            endcase
        end
        if (!st_reg.bpos[OB]) begin
            st_mid.bpos = st_reg.bpos + (OB+1)'(1);
        end
    end

    assign total   = st_mid.bpos;
    assign end_pos = total[OB-1:0];

    always_comb begin
        line_v   = 1'b0;
        line_rec = start_rec(st_mid, end_pos);
        if (eol_path) begin
            if (st_reg.phase == PH_START) begin
                line_v   = 1'b1;
                line_rec = start_rec(st_reg, pos);
            end else begin
                line_v   = (pos != st_reg.line_begin) && st_reg.colon_seen;
                line_rec = header_rec(st_reg, pos);
            end
        end else if (s_tlast) begin
            if (st_mid.phase == PH_START) begin
                line_v   = 1'b1;
                line_rec = start_rec(st_mid, end_pos);
            end else if (st_mid.phase == PH_HEADERS) begin
                line_v   = (end_pos != st_mid.line_begin) && st_mid.colon_seen;
                line_rec = header_rec(st_mid, end_pos);
            end
        end
        line_rec.run_last = !s_tlast;
    end

    always_comb begin
        logic [OB:0] span_len;
        span_len = total - {1'b0, st_mid.body_begin};
        end_v    = s_tlast;
        priority if (total < (OB+1)'(MIN_MESSAGE)) begin
            end_rec = mk_rec(KIND_TOO_SHORT, '0, '0, '0, '0, 1'b0, '0);
        end else if (total[OB]) begin
            end_rec = mk_rec(KIND_TOO_LONG, '0, '0, '0, '0, 1'b0, '0);
        end else if (st_mid.phase != PH_START && st_mid.phase != PH_HEADERS
                     && total > {1'b0, st_mid.body_begin}) begin
            end_rec = mk_rec(KIND_END_OK, st_mid.body_begin, span_len[OB-1:0],
                             '0, '0, 1'b1, '0);
        end else begin
            end_rec = mk_rec(KIND_END_OK, '0, '0, '0, '0, 1'b0, '0);
        end
        end_rec.run_last = 1'b1;
    end

    always_comb begin
        st_next = s_tlast ? reset_state() : st_mid;
    end

    always_comb begin
        logic [CNT_W-1:0] pushed;
        pushed = '0;
        if (in_acc) begin
            pushed = CNT_W'(line_v) + CNT_W'(end_v);
        end
        wr_ptr_next = wr_ptr_reg + PTR_W'(pushed);
        rd_ptr_next = rd_ptr_reg + PTR_W'(out_acc);
        count_next  = count_reg + pushed - CNT_W'(out_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= reset_state();
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (in_acc) begin
                st_reg <= st_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            if (line_v) begin
                queue_reg[wr_ptr_reg] <= line_rec;
            end
            if (end_v) begin
                queue_reg[wr_ptr_reg + PTR_W'(line_v)] <= end_rec;
            end
        end
    end

    assign head    = queue_reg[rd_ptr_reg];
    assign m_tdata = {5'b0, head.status_value, head.part_present, head.second_length,
                      head.second_offset, head.first_length, head.first_offset};
    assign m_tuser = head.kind;
    assign m_tlast = head.run_last;

endmodule
